FILE: sv/hdf_pkg.sv
// shared types, constants and the crc step of the hdlc deframer
package hdf_pkg;

   localparam int MAX_RAW_BITS = 16384;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
   localparam logic [7:0]  MIN_BYTES_RST = 8'd18;
   localparam logic [15:0] CRC_POLY      = 16'h8408;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;
   localparam logic [11:0] TOTAL_MAX     = 12'd4095;

   localparam logic [2:0] ST_GOOD    = 3'd0;
   localparam logic [2:0] ST_FCS     = 3'd1;
   localparam logic [2:0] ST_SHORT   = 3'd2;
   localparam logic [2:0] ST_RUN     = 3'd3;
   localparam logic [2:0] ST_PARTIAL = 3'd4;

   // one entry of the queue between front and back
   typedef struct packed {
      logic        byte_vld;
      logic [7:0]  data;
      logic [1:0]  held_cnt;
      logic        flag;
      logic        frame_end;
      logic [2:0]  pre_status;
      logic [11:0] length;
   } event_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/hdf_front.sv
// front end: nrzi decode, flag hunt, destuffing and byte packing
module hdf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  logic                  accept,
   input  logic                  tone,
   output logic                  ev_vld,
   output hdf_pkg::event_type    ev
);
   import hdf_pkg::*;

   logic [7:0]  min_bytes_ff, min_bytes_in;
   logic        have_ff, have_in;
   logic        prev_ff, prev_in;
   logic [7:0]  win_ff, win_in;
   logic        in_frame_ff, in_frame_in;
   logic [14:0] rc_ff, rc_in;
   logic [2:0]  ones_ff, ones_in;
   logic        bad_ff, bad_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  asm_ff, asm_in;
   logic [11:0] total_ff, total_in;
   logic        bit_v, outgoing, take;
   logic [7:0]  asm_tmp;

   always_comb begin
      min_bytes_in = csr_wr_en ? csr_wr_data : min_bytes_ff;
      have_in      = have_ff;
      prev_in      = prev_ff;
      win_in       = win_ff;
      in_frame_in  = in_frame_ff;
      rc_in        = rc_ff;
      ones_in      = ones_ff;
      bad_in       = bad_ff;
      pos_in       = pos_ff;
      asm_in       = asm_ff;
      total_in     = total_ff;
      bit_v        = 1'b0;
      outgoing     = 1'b0;
      take         = 1'b0;
      asm_tmp      = asm_ff;
      ev           = '0;
      if (accept) begin
         if (!have_ff) begin
            have_in = 1'b1;
            prev_in = tone;
         end else begin
            bit_v    = (tone == prev_ff);
            prev_in  = tone;
            outgoing = win_ff[0];
            win_in   = {bit_v, win_ff[7:1]};
            if (in_frame_ff) begin
               rc_in = rc_ff + 15'd1;
               if (rc_in > 15'(MAX_RAW_BITS)) begin
                  in_frame_in = 1'b0;
                  rc_in       = '0;
               end else if (rc_in > 15'd8 && !bad_ff) begin
                  if (outgoing) begin
                     ones_in = ones_ff + 3'd1;
                     if (ones_in == 3'd7 || ones_in == 3'd0) begin
                        bad_in = 1'b1;
                     end else begin
                        take = 1'b1;
                     end
                  end else begin
                     ones_in = 3'd0;
                     take    = (ones_ff != 3'd5);
                  end
                  if (take) begin
                     asm_tmp[pos_ff] = outgoing;
                     if (pos_ff == 3'd7) begin
                        ev.byte_vld = 1'b1;
                        ev.data     = asm_tmp;
                        ev.held_cnt = (total_ff < 12'd2) ? total_ff[1:0] : 2'd2;
                        total_in    = (total_ff == TOTAL_MAX) ? total_ff : total_ff + 12'd1;
                        asm_in      = '0;
                        pos_in      = '0;
                     end else begin
                        asm_in = asm_tmp;
                        pos_in = pos_ff + 3'd1;
                     end
                  end
               end
            end
            if (win_in == FLAG_BYTE) begin
               ev.flag = 1'b1;
               if (in_frame_in && rc_in > 15'd8) begin
                  ev.frame_end = 1'b1;
                  ev.length    = total_in;
                  if (bad_in) begin
                     ev.pre_status = ST_RUN;
                  end else if (pos_in != 3'd0) begin
                     ev.pre_status = ST_PARTIAL;
                  end else if (total_in < {4'd0, min_bytes_ff} || total_in < 12'd2) begin
                     ev.pre_status = ST_SHORT;
                  end else begin
                     ev.pre_status = ST_GOOD;
                  end
               end
               in_frame_in = 1'b1;
               rc_in       = '0;
               ones_in     = '0;
               bad_in      = 1'b0;
               pos_in      = '0;
               asm_in      = '0;
               total_in    = '0;
            end
         end
      end
   end

   assign ev_vld = ev.byte_vld | ev.flag;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_bytes_ff <= MIN_BYTES_RST;
         have_ff      <= 1'b0;
         prev_ff      <= 1'b0;
         win_ff       <= '0;
         in_frame_ff  <= 1'b0;
         rc_ff        <= '0;
         ones_ff      <= '0;
         bad_ff       <= 1'b0;
         pos_ff       <= '0;
         asm_ff       <= '0;
         total_ff     <= '0;
      end else begin
         min_bytes_ff <= min_bytes_in;
         have_ff      <= have_in;
         prev_ff      <= prev_in;
         win_ff       <= win_in;
         in_frame_ff  <= in_frame_in;
         rc_ff        <= rc_in;
         ones_ff      <= ones_in;
         bad_ff       <= bad_in;
         pos_ff       <= pos_in;
         asm_ff       <= asm_in;
         total_ff     <= total_in;
      end
   end

endmodule

FILE: sv/hdf_queue.sv
// short event queue between front and back
module hdf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hdf_pkg::event_type    push_ev,
   output logic                  full,
   output logic                  head_vld,
   output hdf_pkg::event_type    head_ev,
   input  logic                  pop
);
   import hdf_pkg::*;

   event_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_vld = (count_ff != '0);
   assign head_ev  = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && head_vld;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("event queue over its depth");

endmodule

FILE: sv/hdf_back.sv
// back end: two-byte hold, crc-16 check and result register
module hdf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_vld,
   input  hdf_pkg::event_type    head_ev,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_byte_valid,
   output logic                  rsp_frame_end,
   output logic [2:0]            rsp_frame_status,
   output logic [11:0]           rsp_frame_length
);
   import hdf_pkg::*;

   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [15:0] crc_ff, crc_in;
   logic        emit;
   logic [2:0]  status;
   logic        res_vld;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff;
   logic        bvld_ff;
   logic        end_ff;
   logic [2:0]  status_ff;
   logic [11:0] length_ff;

   assign pop  = head_vld && (!valid_ff || rsp_ready);
   assign emit = head_ev.byte_vld && (head_ev.held_cnt == 2'd2);

   always_comb begin
      held0_in = held0_ff;
      held1_in = held1_ff;
      crc_in   = crc_ff;
      status   = ST_GOOD;
      if (head_ev.byte_vld) begin
         if (emit) begin
            crc_in   = crc16_byte(crc_ff, held0_ff);
            held0_in = held1_ff;
            held1_in = head_ev.data;
         end else if (head_ev.held_cnt == 2'd0) begin
            held0_in = head_ev.data;
         end else begin
            held1_in = head_ev.data;
         end
      end
      if (head_ev.frame_end) begin
         if (head_ev.pre_status != ST_GOOD) begin
            status = head_ev.pre_status;
         end else if ((crc_in ^ CRC_XOROUT) != {held1_in, held0_in}) begin
            status = ST_FCS;
         end
      end
      if (head_ev.flag) begin
         held0_in = '0;
         held1_in = '0;
         crc_in   = CRC_INIT;
      end
   end

   assign res_vld  = emit || head_ev.frame_end;
   assign valid_in = pop ? res_vld : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         held0_ff <= '0;
         held1_ff <= '0;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            held0_ff <= held0_in;
            held1_ff <= held1_in;
            crc_ff   <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && res_vld) begin
         data_ff   <= emit ? held0_ff : 8'd0;
         bvld_ff   <= emit;
         end_ff    <= head_ev.frame_end;
         status_ff <= head_ev.frame_end ? status : ST_GOOD;
         length_ff <= head_ev.frame_end ? head_ev.length : 12'd0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_byte_valid   = bvld_ff;
   assign rsp_frame_end    = end_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_frame_length = length_ff;

   a_beat_has_content: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (bvld_ff || end_ff))
      else $error("result beat carries neither byte nor frame end");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !end_ff) |-> (status_ff == ST_GOOD && length_ff == 12'd0))
      else $error("status or length outside frame end");

   a_flag_restarts_crc: assert property (@(posedge clock) disable iff (reset)
      (pop && head_ev.flag) |=> (crc_ff == CRC_INIT && held0_ff == 8'd0 && held1_ff == 8'd0))
      else $error("flag did not restart the crc and hold");

endmodule

FILE: sv/nrzi_hdlc_deframer_fcs_check.sv
// top level of the nrzi hdlc deframer with crc-16 frame check
// Takes one demodulated tone per req beat and accepts a beat every cycle while the
// four-entry event queue between the front end and the crc back end has room; the
// front end does nrzi decoding, flag hunting, destuffing and byte packing as each
// tone is accepted, the back end retires one queued event per cycle into a result
// register while it is empty or rsp_ready is high, so a result passes through a
// queue entry and then the result register. Frame bytes come out with the two fcs
// bytes withheld; a closing flag gives a frame_end beat with status and destuffed
// length. min_frame_bytes is written through csr_wr_en/csr_wr_data, resets to 18.
module nrzi_hdlc_deframer_fcs_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_tone,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_frame_end,
   output logic [2:0]  rsp_frame_status,
   output logic [11:0] rsp_frame_length
);
   import hdf_pkg::*;

   logic      accept;
   logic      ev_vld;
   event_type ev;
   logic      full;
   logic      head_vld;
   event_type head_ev;
   logic      pop;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   hdf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .tone        (req_tone),
      .ev_vld      (ev_vld),
      .ev          (ev)
   );

   hdf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (ev_vld),
      .push_ev  (ev),
      .full     (full),
      .head_vld (head_vld),
      .head_ev  (head_ev),
      .pop      (pop)
   );

   hdf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_vld         (head_vld),
      .head_ev          (head_ev),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

FILE: tb/sv/tb_nrzi_hdlc_deframer_fcs_check.sv
// testbench for the nrzi hdlc deframer: directed and random tone streams against a local model
`timescale 1ns / 100ps

module tb_nrzi_hdlc_deframer_fcs_check;
   import hdf_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic [7:0]  data;
      logic        byte_vld;
      logic        frame_end;
      logic [2:0]  status;
      logic [11:0] length;
   } rx_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic        req_tone;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_data_byte;
   logic        rsp_byte_valid;
   logic        rsp_frame_end;
   logic [2:0]  rsp_frame_status;
   logic [11:0] rsp_frame_length;

   nrzi_hdlc_deframer_fcs_check DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_tone         (req_tone),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length)
   );

   always #6 clock = ~clock;

   // stimulus and scoreboard storage
   logic        tone_queue[$];
   rx_beat_type awaited[$];
   logic [7:0]  frame_body[$];

   int  cycles;
   int  fails;
   int  tones_made;
   int  byte_beats;
   int  input_stalls;
   int  frame_ends[0:4];
   logic req_fired;
   logic hold_request;

   // line coder state
   logic line_level;
   int   stuff_run;

   // deframer model state
   logic [7:0]  min_bytes;
   logic        line_primed;
   logic        line_prev;
   logic [7:0]  shift_win;
   logic        framing;
   int          raw_bits;
   logic [2:0]  ones_seen;
   logic        run_broken;
   int          bit_idx;
   logic [7:0]  assembling;
   logic [7:0]  delay_byte[0:1];
   int          frame_bytes;
   logic [15:0] crc_acc;

   function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] v);
      logic [15:0] c;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ v[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   task automatic open_frame();
      framing       = 1'b1;
      raw_bits      = 0;
      ones_seen     = 3'd0;
      run_broken    = 1'b0;
      bit_idx       = 0;
      assembling    = 8'h00;
      delay_byte[0] = 8'h00;
      delay_byte[1] = 8'h00;
      frame_bytes   = 0;
      crc_acc       = CRC_INIT;
   endtask

   task automatic destuff_bit(input logic fb, output logic got, output logic [7:0] got_val);
      logic       keep;
      int         slot;
      logic [7:0] done_octet;
      got     = 1'b0;
      got_val = 8'h00;
      keep    = 1'b0;
      if (!run_broken) begin
         keep = 1'b1;
         if (fb) begin
            ones_seen = ones_seen + 3'd1;
            if (ones_seen == 3'd7) begin
               run_broken = 1'b1;
               keep       = 1'b0;
            end
         end else begin
            if (ones_seen == 3'd5) begin
               keep = 1'b0;
            end
            ones_seen = 3'd0;
         end
      end
      if (keep) begin
         assembling[bit_idx] = fb;
         bit_idx++;
         if (bit_idx == 8) begin
            done_octet = assembling;
            assembling = 8'h00;
            bit_idx    = 0;
            slot       = (frame_bytes < 2) ? frame_bytes : 2;
            if (frame_bytes < TOTAL_MAX) begin
               frame_bytes++;
            end
            if (slot == 2) begin
               got           = 1'b1;
               got_val       = delay_byte[0];
               crc_acc       = fcs_update(crc_acc, delay_byte[0]);
               delay_byte[0] = delay_byte[1];
               delay_byte[1] = done_octet;
            end else begin
               delay_byte[slot] = done_octet;
            end
         end
      end
   endtask

   task automatic deframe_tone(input logic t);
      logic        lbit;
      logic        outgoing;
      logic        got;
      logic        closed;
      logic [7:0]  got_val;
      logic [2:0]  st;
      rx_beat_type beat;
      got     = 1'b0;
      got_val = 8'h00;
      closed  = 1'b0;
      st      = ST_GOOD;
      beat    = '0;
      if (!line_primed) begin
         line_primed = 1'b1;
         line_prev   = t;
      end else begin
         lbit      = (t == line_prev);
         line_prev = t;
         outgoing  = shift_win[0];
         shift_win = {lbit, shift_win[7:1]};
         if (framing) begin
            raw_bits++;
            if (raw_bits > MAX_RAW_BITS) begin
               framing  = 1'b0;
               raw_bits = 0;
            end else if (raw_bits > 8) begin
               destuff_bit(outgoing, got, got_val);
            end
         end
         if (shift_win == FLAG_BYTE) begin
            if (framing && raw_bits > 8) begin
               closed = 1'b1;
               if (run_broken) begin
                  st = ST_RUN;
               end else if (bit_idx != 0) begin
                  st = ST_PARTIAL;
               end else if (frame_bytes < min_bytes || frame_bytes < 2) begin
                  st = ST_SHORT;
               end else if ((crc_acc ^ CRC_XOROUT) != {delay_byte[1], delay_byte[0]}) begin
                  st = ST_FCS;
               end
               beat.frame_end = 1'b1;
               beat.status    = st;
               beat.length    = 12'(frame_bytes);
               frame_ends[st]++;
            end
            open_frame();
         end
         if (got) begin
            beat.data     = got_val;
            beat.byte_vld = 1'b1;
            byte_beats++;
         end
         if (got || closed) begin
            awaited.push_back(beat);
         end
      end
   endtask

   // line coding of the stimulus
   task automatic push_tone(input logic t);
      tone_queue.push_back(t);
      line_level = t;
      tones_made++;
   endtask

   task automatic line_bit(input logic b);
      push_tone(b ? line_level : ~line_level);
   endtask

   task automatic send_flag();
      for (int i = 0; i < 8; i++) begin
         line_bit(FLAG_BYTE[i]);
      end
      stuff_run = 0;
   endtask

   task automatic frame_bit(input logic b);
      line_bit(b);
      if (b) begin
         stuff_run++;
         if (stuff_run == 5) begin
            line_bit(1'b0);
            stuff_run = 0;
         end
      end else begin
         stuff_run = 0;
      end
   endtask

   task automatic frame_octet(input logic [7:0] v);
      for (int i = 0; i < 8; i++) begin
         frame_bit(v[i]);
      end
   endtask

   function automatic logic [7:0] pick_octet();
      logic [7:0] awkward[0:5];
      awkward = '{8'hFF, 8'h7E, 8'h7F, 8'hFE, 8'h00, 8'h3F};
      if ($urandom_range(0, 3) == 0) begin
         return awkward[$urandom_range(0, 5)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic fill_body(input int n);
      frame_body.delete();
      repeat (n) begin
         frame_body.push_back(pick_octet());
      end
   endtask

   // flag, body, optional fcs, optional odd bits, flag; abort_at puts seven raw ones ahead of that octet
   task automatic send_frame(input logic bad_fcs, input int tail_bits, input int abort_at,
                             input logic with_fcs);
      logic [15:0] acc;
      logic [15:0] fcs;
      acc = CRC_INIT;
      send_flag();
      for (int i = 0; i < frame_body.size(); i++) begin
         if (i == abort_at) begin
            repeat (7) begin
               line_bit(1'b1);
            end
            stuff_run = 0;
         end
         frame_octet(frame_body[i]);
         acc = fcs_update(acc, frame_body[i]);
      end
      if (with_fcs) begin
         fcs = acc ^ CRC_XOROUT;
         if (bad_fcs) begin
            fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
         end
         frame_octet(fcs[7:0]);
         frame_octet(fcs[15:8]);
      end
      repeat (tail_bits) begin
         frame_bit(1'($urandom_range(0, 1)));
      end
      send_flag();
   endtask

   task automatic wait_drained();
      while (tone_queue.size() != 0 || req_valid || awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_bytes(input logic [7:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      min_bytes = v;
   endtask

   // sender: bursts of beats with random gaps
   int gap_left;
   int burst_left;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_tone  <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (tone_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_tone  <= tone_queue.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 40);
               gap_left   = $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: changing stall styles plus one long hold-off
   int hold_left;
   int style_left;
   int ready_style;
   logic [1:0] stall_tick;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request && hold_left == 0) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               ready_style = $urandom_range(0, 3);
               style_left  = $urandom_range(16, 96);
            end else begin
               style_left--;
            end
            stall_tick = stall_tick + 2'd1;
            case (ready_style)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_ready <= (stall_tick != 2'd0);
               end
               default: begin
                  rsp_ready <= ($urandom_range(0, 7) == 0);
               end
            endcase
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin : monitor
      rx_beat_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_ready;
         if (req_valid && !req_ready) begin
            input_stalls++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               $error("result beat with nothing expected: data %0h end %0b status %0d",
                      rsp_data_byte, rsp_frame_end, rsp_frame_status);
               fails++;
            end else begin
               want = awaited.pop_front();
               if (rsp_data_byte !== want.data) begin
                  $error("rsp_data_byte expected %0h got %0h", want.data, rsp_data_byte);
                  fails++;
               end
               if (rsp_byte_valid !== want.byte_vld) begin
                  $error("rsp_byte_valid expected %0b got %0b", want.byte_vld, rsp_byte_valid);
                  fails++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("rsp_frame_end expected %0b got %0b", want.frame_end, rsp_frame_end);
                  fails++;
               end
               if (rsp_frame_status !== want.status) begin
                  $error("rsp_frame_status expected %0d got %0d", want.status, rsp_frame_status);
                  fails++;
               end
               if (rsp_frame_length !== want.length) begin
                  $error("rsp_frame_length expected %0d got %0d", want.length, rsp_frame_length);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            deframe_tone(req_tone);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected", cycles, awaited.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int seg;
      int seg_start;
      int seg_frames;
      int kind;
      int n;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 8'h00;
      req_valid    = 1'b0;
      req_tone     = 1'b0;
      rsp_ready    = 1'b0;
      hold_request = 1'b0;
      cycles       = 0;
      fails        = 0;
      tones_made   = 0;
      byte_beats   = 0;
      input_stalls = 0;
      gap_left     = 0;
      burst_left   = 0;
      hold_left    = 0;
      style_left   = 0;
      ready_style  = 0;
      stall_tick   = 2'd0;
      for (int i = 0; i <= 4; i++) begin
         frame_ends[i] = 0;
      end
      line_level   = 1'b0;
      stuff_run    = 0;
      min_bytes    = MIN_BYTES_RST;
      line_primed  = 1'b0;
      line_prev    = 1'b0;
      shift_win    = 8'h00;
      open_frame();
      framing      = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset threshold: back-to-back flags, good, short, bad fcs
      push_tone(1'($urandom_range(0, 1)));
      send_flag();
      send_flag();
      send_flag();
      fill_body(16);
      send_frame(1'b0, 0, -1, 1'b1);
      fill_body(10);
      send_frame(1'b0, 0, -1, 1'b1);
      fill_body(16);
      send_frame(1'b1, 0, -1, 1'b1);
      wait_drained();

      // lowest threshold and the odd frame shapes
      write_min_bytes(8'd3);
      fill_body(1);
      send_frame(1'b0, 0, -1, 1'b1);
      fill_body(0);
      send_frame(1'b0, 0, -1, 1'b1);
      frame_body.delete();
      frame_body.push_back(8'hFF);
      send_frame(1'b0, 0, -1, 1'b0);
      frame_body.delete();
      frame_body.push_back(8'h00);
      send_frame(1'b0, 0, -1, 1'b0);
      frame_body.delete();
      frame_body.push_back(8'hFF);
      frame_body.push_back(8'h7E);
      frame_body.push_back(8'hFE);
      frame_body.push_back(8'h00);
      frame_body.push_back(8'h7F);
      send_frame(1'b0, 0, -1, 1'b1);
      send_frame(1'b1, 0, -1, 1'b1);
      fill_body(4);
      send_frame(1'b0, 3, -1, 1'b1);
      fill_body(0);
      send_frame(1'b1, 2, -1, 1'b1);
      fill_body(5);
      send_frame(1'b0, 0, 2, 1'b1);
      fill_body(5);
      send_frame(1'b0, 5, 0, 1'b1);
      repeat (30) push_tone(1'($urandom_range(0, 1)));
      fill_body(3);
      send_frame(1'b0, 0, -1, 1'b1);
      // over-long frame loses framing at the raw bit limit and gets no end beat
      fill_body(2070);
      send_frame(1'b0, 0, -1, 1'b1);
      fill_body(2);
      send_frame(1'b0, 0, -1, 1'b1);
      wait_drained();

      // highest threshold
      write_min_bytes(8'd255);
      fill_body(16);
      send_frame(1'b0, 0, -1, 1'b1);
      fill_body(253);
      send_frame(1'b0, 0, -1, 1'b1);
      fill_body(252);
      send_frame(1'b0, 0, -1, 1'b1);
      wait_drained();

      // random frames, mostly well formed
      for (seg = 0; seg < 3; seg++) begin
         write_min_bytes(8'($urandom_range(3, 12)));
         seg_start  = tones_made;
         seg_frames = 0;
         while (tones_made - seg_start < 170 || seg_frames < 5) begin
            kind = $urandom_range(0, 99);
            if (kind >= 90) begin
               repeat ($urandom_range(5, 40)) push_tone(1'($urandom_range(0, 1)));
            end else begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 8);
               fill_body(n);
               repeat ($urandom_range(0, 2)) send_flag();
               send_frame($urandom_range(0, 4) == 0,
                          (kind >= 70 && kind < 80) ? $urandom_range(1, 7) : 0,
                          (kind >= 80 && n > 0) ? $urandom_range(0, n - 1) : -1, 1'b1);
               seg_frames++;
            end
         end
         if (seg == 0) begin
            hold_request = 1'b1;
         end
         wait_drained();
      end

      $display("covered %0d tones, %0d byte beats, frame ends good %0d fcs %0d short %0d",
               tones_made, byte_beats, frame_ends[ST_GOOD], frame_ends[ST_FCS],
               frame_ends[ST_SHORT]);
      $display("  long ones %0d partial %0d, input held off for %0d cycles",
               frame_ends[ST_RUN], frame_ends[ST_PARTIAL], input_stalls);
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: nrzi_hdlc_deframer_fcs_check.f
sv/hdf_pkg.sv
sv/hdf_front.sv
sv/hdf_queue.sv
sv/hdf_back.sv
sv/nrzi_hdlc_deframer_fcs_check.sv
tb/sv/tb_nrzi_hdlc_deframer_fcs_check.sv
